// File: sv/bcdq_pkg.sv
// Shared constants for the bounded circular deque: field widths, operation codes
// and configuration defaults. No dependencies.
package bcdq_pkg;

	localparam int DATA_W        = 32;
	localparam int MODE_W        = 3;
	localparam int CAP_W         = 11;
	localparam int DEPTH_DEFAULT = 1024;
	localparam int CAP_RESET     = 1024;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd4;

endpackage

// File: sv/bcdq_ring_mem.sv
// Slot storage of the deque: one write port and two registered read ports.
// Depends on bcdq_pkg for the data width.
module bcdq_ring_mem #(
	parameter int DEPTH = bcdq_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [bcdq_pkg::DATA_W-1:0] wr_data,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr_b,
	output logic [bcdq_pkg::DATA_W-1:0] rd_data_a,
	output logic [bcdq_pkg::DATA_W-1:0] rd_data_b
);
	import bcdq_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// File: sv/bounded_circular_deque.sv
// Bounded double-ended queue held in a ring buffer with head, tail and count.
// Depends on bcdq_pkg and bcdq_ring_mem.
// An input transfer writes the slot and moves the pointers; the new front and rear
// slots are then read through the registered read ports, and the result is registered
// for the output. A new request is taken only once that result has been loaded.
// Reset clears the pointers and the count and sets the capacity to the smaller
// of 1024 and DEPTH; slot contents stay undefined until pushed.
module bounded_circular_deque #(
	parameter int DEPTH = bcdq_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [bcdq_pkg::CAP_W-1:0]         cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bcdq_pkg::MODE_W-1:0]        mode,
	input  logic signed [bcdq_pkg::DATA_W-1:0] push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic signed [bcdq_pkg::DATA_W-1:0] front_value,
	output logic signed [bcdq_pkg::DATA_W-1:0] rear_value,
	output logic                               values_valid,
	output logic                               is_empty,
	output logic                               is_full,
	output logic [bcdq_pkg::CAP_W-1:0]         item_count
);
	import bcdq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CAP_TOP = (2 ** CAP_W) - 1;
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'((DEPTH < CAP_TOP) ? DEPTH : CAP_TOP);
	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CAP_W-1:0] count_q;
	logic [CAP_W-1:0] cap_q;
	logic             acc_q;
	logic             out_valid_q;

	logic             in_xfer;
	logic             full;
	logic             empty;
	logic [PTR_W-1:0] head_next;
	logic [PTR_W-1:0] head_prev;
	logic [PTR_W-1:0] tail_next;
	logic [PTR_W-1:0] tail_prev;
	logic             op_ok;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [DATA_W-1:0] rd_front;
	logic [DATA_W-1:0] rd_rear;
	logic             load_out;
	logic             res_empty;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign full      = (count_q >= cap_q);
	assign empty     = (count_q == '0);
	assign head_next = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign head_prev = (head_q == '0) ? PTR_LAST : head_q - PTR_W'(1);
	assign tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign tail_prev = (tail_q == '0) ? PTR_LAST : tail_q - PTR_W'(1);

	always_comb begin
		op_ok   = 1'b1;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		unique case (mode)
			MODE_PUSH_FRONT: begin
				op_ok   = !full;
				wr_en   = in_xfer && !full;
				wr_addr = head_prev;
			end
			MODE_PUSH_BACK: begin
				op_ok   = !full;
				wr_en   = in_xfer && !full;
				wr_addr = tail_q;
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				op_ok = !empty;
			end
			default: begin
				op_ok = 1'b1;
			end
		endcase
	end

	bcdq_ring_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (push_value),
		.rd_addr_a(head_q),
		.rd_addr_b(tail_prev),
		.rd_data_a(rd_front),
		.rd_data_b(rd_rear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			acc_q   <= 1'b0;
		end else if (in_xfer) begin
			acc_q <= op_ok;
			if (op_ok) begin
				unique case (mode)
					MODE_PUSH_FRONT: begin
						head_q  <= head_prev;
						count_q <= count_q + CAP_W'(1);
					end
					MODE_PUSH_BACK: begin
						tail_q  <= tail_next;
						count_q <= count_q + CAP_W'(1);
					end
					MODE_POP_FRONT: begin
						head_q  <= head_next;
						count_q <= count_q - CAP_W'(1);
					end
					MODE_POP_BACK: begin
						tail_q  <= tail_prev;
						count_q <= count_q - CAP_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RST;
		end else if (cfg_wr_en && empty) begin
			if (cfg_wr_data == '0) begin
				cap_q <= CAP_W'(1);
			end else if (cfg_wr_data > CAP_MAX) begin
				cap_q <= CAP_MAX;
			end else begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign res_empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted     <= acc_q;
			front_value  <= res_empty ? '0 : rd_front;
			rear_value   <= res_empty ? '0 : rd_rear;
			values_valid <= !res_empty;
			is_empty     <= res_empty;
			is_full      <= full;
			item_count   <= count_q;
		end
	end

	assign out_valid = out_valid_q;

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("item count exceeds the capacity limit");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (head_q == tail_q))
		else $error("head and tail differ while the deque is empty");

	a_xfer_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_READ))
		else $error("input transfer did not start a slot read");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result offered without a completed slot read");

endmodule

// File: tb/sv/bounded_circular_deque_tb.sv
// Self-checking testbench for bounded_circular_deque: a directed table, then random
// deque traffic under several capacities and idling patterns, checked by a behavioral deque.
// Depends on bcdq_pkg and the block's RTL.
module bounded_circular_deque_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcdq_pkg::*;

	localparam int SLOTS       = DEPTH_DEFAULT;
	localparam int RUN_LIMIT   = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 128;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		logic                     accepted;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] rear;
		logic                     values_valid;
		logic                     is_empty;
		logic                     is_full;
		logic [CAP_W-1:0]         count;
	} deque_snapshot_t;

	typedef struct {
		bit                       cfg_write;
		logic [CAP_W-1:0]         cfg_data;
		logic [MODE_W-1:0]        op;
		logic signed [DATA_W-1:0] value;
		bit                       typed;
		deque_snapshot_t          want;
	} table_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [MODE_W-1:0]        mode = MODE_QUERY;
	logic signed [DATA_W-1:0] push_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b1;
	logic                     accepted;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic                     values_valid;
	logic                     is_empty;
	logic                     is_full;
	logic [CAP_W-1:0]         item_count;

	logic signed [DATA_W-1:0] model_slots [SLOTS];
	int                       model_head = 0;
	int                       model_tail = 0;
	int                       model_count = 0;
	int                       model_cap = (CAP_RESET < SLOTS) ? CAP_RESET : SLOTS;

	deque_snapshot_t awaited_snapshots [$];
	int              error_count = 0;
	int              result_index = 0;
	int              gap_pct = 0;
	int              stall_pct = 0;

	bounded_circular_deque i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accepted     (accepted),
		.front_value  (front_value),
		.rear_value   (rear_value),
		.values_valid (values_valid),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.item_count   (item_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic int ring_prev(input int idx);
		return (idx == 0) ? SLOTS - 1 : idx - 1;
	endfunction

	function automatic int ring_next(input int idx);
		return (idx == SLOTS - 1) ? 0 : idx + 1;
	endfunction

	task automatic apply_deque_op(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] value, output deque_snapshot_t snap);
		bit ok;
		ok = 1'b1;
		case (op)
			MODE_PUSH_FRONT: begin
				if (model_count >= model_cap) begin
					ok = 1'b0;
				end else begin
					model_head = ring_prev(model_head);
					model_slots[model_head] = value;
					model_count++;
				end
			end
			MODE_PUSH_BACK: begin
				if (model_count >= model_cap) begin
					ok = 1'b0;
				end else begin
					model_slots[model_tail] = value;
					model_tail = ring_next(model_tail);
					model_count++;
				end
			end
			MODE_POP_FRONT: begin
				if (model_count == 0) begin
					ok = 1'b0;
				end else begin
					model_head = ring_next(model_head);
					model_count--;
				end
			end
			MODE_POP_BACK: begin
				if (model_count == 0) begin
					ok = 1'b0;
				end else begin
					model_tail = ring_prev(model_tail);
					model_count--;
				end
			end
			default: begin
			end
		endcase
		snap.accepted = ok;
		if (model_count == 0) begin
			snap.front = '0;
			snap.rear = '0;
			snap.values_valid = 1'b0;
		end else begin
			snap.front = model_slots[model_head];
			snap.rear = model_slots[ring_prev(model_tail)];
			snap.values_valid = 1'b1;
		end
		snap.is_empty = (model_count == 0);
		snap.is_full = (model_count >= model_cap);
		snap.count = CAP_W'(model_count);
	endtask

	task automatic apply_capacity_write(input logic [CAP_W-1:0] data);
		if (model_count == 0) begin
			if (data == 0) model_cap = 1;
			else if (int'(data) > SLOTS) model_cap = SLOTS;
			else model_cap = int'(data);
		end
	endtask

	function automatic table_row_t op_row(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] value);
		table_row_t row;
		row.cfg_write = 1'b0;
		row.cfg_data = '0;
		row.op = op;
		row.value = value;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic table_row_t checked_row(input logic [MODE_W-1:0] op,
			input logic signed [DATA_W-1:0] value, input logic acc,
			input logic signed [DATA_W-1:0] front, input logic signed [DATA_W-1:0] rear,
			input logic vv, input logic empty, input logic full, input logic [CAP_W-1:0] cnt);
		table_row_t row;
		row = op_row(op, value);
		row.typed = 1'b1;
		row.want = '{acc, front, rear, vv, empty, full, cnt};
		return row;
	endfunction

	function automatic table_row_t cfg_row(input logic [CAP_W-1:0] data);
		table_row_t row;
		row = op_row(MODE_QUERY, '0);
		row.cfg_write = 1'b1;
		row.cfg_data = data;
		return row;
	endfunction

	task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] value,
			input bit typed, input deque_snapshot_t want);
		deque_snapshot_t snap;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		push_value <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_deque_op(op, value, snap);
		awaited_snapshots.push_back(typed ? want : snap);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_snapshots.size() != 0) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		apply_capacity_write(data);
	endtask

	task automatic drain_deque();
		while (model_count > 0) begin
			send_op($urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK, $urandom, 1'b0, '0);
		end
	endtask

	task automatic send_random_op(input int push_pct);
		logic [MODE_W-1:0]        op;
		logic signed [DATA_W-1:0] value;
		int                       pick;
		pick = $urandom_range(99);
		if (pick < 3) op = MODE_W'(5 + $urandom_range(2));
		else if (pick < 10) op = MODE_QUERY;
		else if ($urandom_range(99) < push_pct)
			op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
		else
			op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
		case ($urandom_range(7))
			0: value = 32'sh7FFF_FFFF;
			1: value = 32'sh8000_0000;
			2: value = '0;
			3: value = -32'sd1;
			default: value = $urandom;
		endcase
		send_op(op, value, 1'b0, '0);
	endtask

	task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (error_count < PRINT_LIMIT)
			$display("Result %0d: %s is %h, expected %h.", result_index, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		deque_snapshot_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_snapshots.size() == 0) begin
				note_mismatch("unexpected transfer", '0, '0);
			end else begin
				want = awaited_snapshots.pop_front();
				if (accepted !== want.accepted)
					note_mismatch("accepted", DATA_W'(accepted), DATA_W'(want.accepted));
				if (front_value !== want.front)
					note_mismatch("front_value", front_value, want.front);
				if (rear_value !== want.rear)
					note_mismatch("rear_value", rear_value, want.rear);
				if (values_valid !== want.values_valid)
					note_mismatch("values_valid", DATA_W'(values_valid),
						DATA_W'(want.values_valid));
				if (is_empty !== want.is_empty)
					note_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.is_empty));
				if (is_full !== want.is_full)
					note_mismatch("is_full", DATA_W'(is_full), DATA_W'(want.is_full));
				if (item_count !== want.count)
					note_mismatch("item_count", DATA_W'(item_count), DATA_W'(want.count));
			end
			result_index++;
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		table_row_t       steps [$];
		logic [CAP_W-1:0] phase_caps [PHASES];
		int               push_pct;

		// Empty deque after reset, refused pops and unused modes.
		steps.push_back(checked_row(MODE_QUERY, '0, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		steps.push_back(checked_row(MODE_POP_FRONT, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		steps.push_back(checked_row(MODE_POP_BACK, -32'sd1, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0,
			11'd0));
		steps.push_back(checked_row(3'd5, '0, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		steps.push_back(checked_row(3'd7, -32'sd1, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		// The first push at the front wraps the head pointer below zero.
		steps.push_back(checked_row(MODE_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, 11'd1));
		steps.push_back(checked_row(MODE_PUSH_BACK, 32'sh8000_0000, 1'b1,
			32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 11'd2));
		steps.push_back(checked_row(3'd6, 32'sh1234_5678, 1'b1,
			32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, 11'd2));
		steps.push_back(op_row(MODE_PUSH_FRONT, -32'sd1));
		steps.push_back(op_row(MODE_PUSH_BACK, '0));
		steps.push_back(op_row(MODE_POP_BACK, '0));
		steps.push_back(op_row(MODE_POP_FRONT, '0));
		// A capacity write while items are held has no effect.
		steps.push_back(cfg_row(11'd3));
		steps.push_back(op_row(MODE_POP_FRONT, '0));
		steps.push_back(op_row(MODE_POP_BACK, '0));
		steps.push_back(checked_row(MODE_POP_FRONT, '0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		// A pop at the back with the tail at slot zero wraps the tail pointer.
		steps.push_back(op_row(MODE_PUSH_FRONT, 32'sh5555_5555));
		steps.push_back(op_row(MODE_POP_BACK, '0));
		// A capacity of zero is taken as one.
		steps.push_back(cfg_row(11'd0));
		steps.push_back(checked_row(MODE_PUSH_BACK, 32'shAAAA_AAAA, 1'b1,
			32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b1, 1'b0, 1'b1, 11'd1));
		steps.push_back(checked_row(MODE_PUSH_FRONT, 32'sd1, 1'b0,
			32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b1, 1'b0, 1'b1, 11'd1));
		steps.push_back(checked_row(MODE_PUSH_BACK, 32'sd2, 1'b0,
			32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b1, 1'b0, 1'b1, 11'd1));
		steps.push_back(op_row(MODE_QUERY, '0));
		steps.push_back(checked_row(MODE_POP_FRONT, '0, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 11'd0));
		steps.push_back(cfg_row(11'd2047));

		phase_caps = '{11'd5, 11'd0, 11'd1024, 11'd2047, 11'd2, 11'd1, 11'd16,
			CAP_W'($urandom_range(2047))};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].cfg_write) write_capacity(steps[i].cfg_data);
			else send_op(steps[i].op, steps[i].value, steps[i].typed, steps[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if ($urandom_range(3) != 0) drain_deque();
			write_capacity(phase_caps[ph]);
			gap_pct = (ph % 4 == 1) ? 82 : (ph % 4 == 3) ? 20 : 0;
			stall_pct = (ph % 4 == 2) ? 82 : (ph % 4 == 3) ? 20 : 0;
			push_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 16 == 0) begin
					case ($urandom_range(2))
						0: push_pct = 85;
						1: push_pct = 50;
						default: push_pct = 15;
					endcase
				end
				send_random_op(push_pct);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_snapshots.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (error_count == 0 && awaited_snapshots.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
